### hdl/escape_sequence_decoder_assert.svh
// Assertion macros for the escape sequence decoder.
// Each macro expects clk and arst_n in scope.
`ifndef ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

// Property that must hold at every edge out of reset
`define ESD_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Same-cycle implication
`define ESD_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

### hdl/esd_pkg.sv
package esd_pkg;

	localparam int CH_W    = 8;
	localparam int VAL_W   = 12;
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 3;
	localparam int MODE_W  = 3;

	// decoder modes
	localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ESC   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CARET = 3'd2;
	localparam logic [MODE_W-1:0] MODE_HEX   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_OCT   = 3'd4;

	// special characters
	localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CH_W-1:0] CH_CARET  = 8'h5E;
	localparam logic [CH_W-1:0] CH_AT     = 8'h40;
	localparam logic [CH_W-1:0] CH_ESCAPE = 8'h1B;

	// classified character, produced by the front end
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            is_nul;
		logic            is_bslash;
		logic            is_caret;
		logic            is_x;
		logic            is_hex;
		logic            is_oct;
		logic            esc_hit;
		logic [CH_W-1:0] esc_val;
		logic [3:0]      hex_val;
		logic [CH_W-1:0] ctl_val;
	} esd_token_t;

	// one decoded symbol
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             last;
	} esd_result_t;

	// back end status for checking
	typedef struct packed {
		logic [OUT_CNT_W-1:0] out_count;
		logic                 tok_pop;
	} esd_back_stat_t;

	function automatic logic [CH_W-1:0] to_upper(input logic [CH_W-1:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	// single-letter escapes, keyed on the upper-cased character
	function automatic logic [CH_W:0] esc_lookup(input logic [CH_W-1:0] u);
		logic [CH_W:0] r;
		unique case (u)
			8'h42:   r = {1'b1, 8'h08};
			8'h46:   r = {1'b1, 8'h0C};
			8'h4E:   r = {1'b1, 8'h0A};
			8'h52:   r = {1'b1, 8'h0D};
			8'h53:   r = {1'b1, 8'h20};
			8'h54:   r = {1'b1, 8'h09};
			8'h45:   r = {1'b1, CH_ESCAPE};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### hdl/esd_in_if.sv
interface esd_in_if;
	logic                     valid;
	logic                     ready;
	logic [esd_pkg::CH_W-1:0] ch;

	modport source (output valid, output ch, input ready);
	modport sink   (input valid, input ch, output ready);
endinterface

### hdl/esd_out_if.sv
interface esd_out_if;
	logic                      valid;
	logic                      ready;
	logic [esd_pkg::VAL_W-1:0] value;
	logic                      last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

### hdl/esd_front.sv
module esd_front (
	esd_in_if.sink              chars,
	output logic                tok_valid,
	input  logic                tok_ready,
	output esd_pkg::esd_token_t tok
);
	import esd_pkg::*;

	logic [CH_W-1:0] c;
	logic [CH_W-1:0] u;
	logic [CH_W:0]   esc;
	logic            is_dig;

	assign c = chars.ch;
	assign u = to_upper(c);
	assign esc = esc_lookup(u);
	assign is_dig = (c >= 8'h30) && (c <= 8'h39);

	// classify the character; the queue registers it
	always_comb begin
		tok.ch        = c;
		tok.is_nul    = (c == CH_NUL);
		tok.is_bslash = (c == CH_BSLASH);
		tok.is_caret  = (c == CH_CARET);
		tok.is_x      = (u == 8'h58);
		tok.is_hex    = is_dig || (u >= 8'h41 && u <= 8'h46);
		tok.is_oct    = (c >= 8'h30) && (c <= 8'h37);
		tok.esc_hit   = esc[CH_W];
		tok.esc_val   = esc[CH_W-1:0];
		tok.hex_val   = is_dig ? c[3:0] : c[3:0] + 4'd9;
		tok.ctl_val   = u - CH_AT;
	end

	assign tok_valid   = chars.valid;
	assign chars.ready = tok_ready;
endmodule

### hdl/esd_queue.sv
module esd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  esd_pkg::esd_token_t push_tok,
	output logic                pop_valid,
	input  logic                pop_ready,
	output esd_pkg::esd_token_t pop_tok
);
	import esd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	esd_token_t       mem_q [DEPTH];
	logic [PW-1:0]    head_q, tail_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_tok    = mem_q[head_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[tail_q] <= push_tok;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= ptr_inc(tail_q);
			end
			if (do_pop) begin
				head_q <= ptr_inc(head_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

### hdl/esd_back.sv
module esd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    tok_valid,
	output logic                    tok_ready,
	input  esd_pkg::esd_token_t     tok,
	esd_out_if.source               symbols,
	output esd_pkg::esd_back_stat_t stat
);
	import esd_pkg::*;

	logic [MODE_W-1:0]    mode_q, mode_d;
	logic [VAL_W-1:0]     acc_q, acc_d;
	logic [1:0]           cnt_q, cnt_d, cnt_inc;
	logic [VAL_W-1:0]     acc_hex, acc_oct;

	esd_result_t          mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] head_q, tail_q;
	logic [OUT_CNT_W-1:0] count_q;

	logic                 pop;
	logic                 out_pop;
	logic                 r0v, r1v;
	logic [VAL_W-1:0]     r0, r1;
	logic                 run_end;
	logic                 idle_emit;
	logic [VAL_W-1:0]     ch_ext;
	logic [OUT_CNT_W-1:0] push_n;

	// take a token only when two result slots are free
	assign tok_ready = (count_q <= OUT_CNT_W'(OUT_DEPTH - 2));
	assign pop       = tok_valid && tok_ready;

	assign acc_hex   = {acc_q[VAL_W-5:0], tok.hex_val};
	assign acc_oct   = {acc_q[VAL_W-4:0], tok.ch[2:0]};
	assign cnt_inc   = cnt_q + 2'd1;
	assign idle_emit = !tok.is_nul && !tok.is_bslash;
	assign ch_ext    = {{(VAL_W-CH_W){1'b0}}, tok.ch};

	// execute one token: next mode and up to two results
	always_comb begin
		mode_d  = mode_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		r0v     = 1'b0;
		r0      = '0;
		r1v     = 1'b0;
		r1      = ch_ext;
		run_end = 1'b0;
		if (pop) begin
			unique case (mode_q)
				MODE_ESC: begin
					mode_d = MODE_IDLE;
					if (tok.is_nul) begin
						r0v = 1'b1;
						r0  = {{(VAL_W-CH_W){1'b0}}, CH_BSLASH};
					end else if (tok.esc_hit) begin
						r0v = 1'b1;
						r0  = {{(VAL_W-CH_W){1'b0}}, tok.esc_val};
					end else if (tok.is_caret) begin
						mode_d = MODE_CARET;
					end else if (tok.is_x) begin
						mode_d = MODE_HEX;
						acc_d  = '0;
						cnt_d  = 2'd0;
					end else if (tok.is_oct) begin
						mode_d = MODE_OCT;
						acc_d  = {{(VAL_W-3){1'b0}}, tok.ch[2:0]};
						cnt_d  = 2'd1;
					end else begin
						r0v = 1'b1;
						r0  = ch_ext;
					end
				end
				MODE_CARET: begin
					mode_d = MODE_IDLE;
					r0v    = 1'b1;
					r0     = {{(VAL_W-CH_W){1'b0}}, tok.ctl_val};
				end
				MODE_HEX: begin
					if (tok.is_hex) begin
						acc_d = acc_hex;
						cnt_d = cnt_inc;
						if (cnt_inc == 2'd3) begin
							mode_d = MODE_IDLE;
							r0v    = 1'b1;
							r0     = acc_hex;
						end
					end else begin
						r0v     = 1'b1;
						r0      = acc_q;
						run_end = 1'b1;
					end
				end
				MODE_OCT: begin
					if (tok.is_oct) begin
						acc_d = acc_oct;
						cnt_d = cnt_inc;
						if (cnt_inc == 2'd3) begin
							mode_d = MODE_IDLE;
							r0v    = 1'b1;
							r0     = acc_oct;
						end
					end else begin
						r0v     = 1'b1;
						r0      = acc_q;
						run_end = 1'b1;
					end
				end
				default: begin
					mode_d = tok.is_bslash ? MODE_ESC : MODE_IDLE;
					r0v    = idle_emit;
					r0     = ch_ext;
				end
			endcase
			// run closed by a non-digit: that character is handled afresh
			if (run_end) begin
				mode_d = tok.is_bslash ? MODE_ESC : MODE_IDLE;
				r1v    = idle_emit;
			end
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			cnt_q  <= 2'd0;
		end else begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
		end
	end

	// result buffer
	assign out_pop = symbols.valid && symbols.ready;
	assign push_n  = OUT_CNT_W'(r0v) + OUT_CNT_W'(r1v);

	always_ff @(posedge clk) begin
		if (r0v) begin
			mem_q[tail_q] <= '{value: r0, last: !r1v};
		end
		if (r1v) begin
			mem_q[tail_q + OUT_PTR_W'(1)] <= '{value: r1, last: 1'b1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + push_n[OUT_PTR_W-1:0];
			head_q  <= head_q + OUT_PTR_W'(out_pop);
			count_q <= count_q + push_n - OUT_CNT_W'(out_pop);
		end
	end

	assign symbols.valid = (count_q != '0);
	assign symbols.value = mem_q[head_q].value;
	assign symbols.last  = mem_q[head_q].last;

	assign stat.out_count = count_q;
	assign stat.tok_pop   = pop;
endmodule

### hdl/escape_sequence_decoder.sv
// Channel   Role    Payload        Width
// chars     sink    ch             8
// symbols   source  value, last    12, 1
//
// One character is taken per cycle while the token queue has room; a character that
// closes a digit run and then gives its own symbol yields two results.
// A result passes from the token queue register through execute into the
// four-entry result buffer, from which it is offered on symbols.
// Reset clears all control state at once; there is no clearing pass.
// chars.ready falls when the token queue is full; the executor waits while
// fewer than two result slots are free.
module escape_sequence_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic        clk,
	input logic        arst_n,
	esd_in_if.sink     chars,
	esd_out_if.source  symbols
);
	import esd_pkg::*;

	esd_token_t     fe_tok, be_tok;
	logic           fe_valid, fe_ready;
	logic           be_valid, be_ready;
	esd_back_stat_t stat;

	esd_front u_front (
		.chars     (chars),
		.tok_valid (fe_valid),
		.tok_ready (fe_ready),
		.tok       (fe_tok)
	);

	esd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_tok   (fe_tok),
		.pop_valid  (be_valid),
		.pop_ready  (be_ready),
		.pop_tok    (be_tok)
	);

	esd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (be_valid),
		.tok_ready (be_ready),
		.tok       (be_tok),
		.symbols   (symbols),
		.stat      (stat)
	);

	// checks
`include "escape_sequence_decoder_assert.svh"

	`ESD_ASSERT(a_out_bound, stat.out_count <= OUT_CNT_W'(OUT_DEPTH), "result buffer overflow")
	`ESD_ASSERT_IMP(a_pop_room, stat.tok_pop, stat.out_count <= OUT_CNT_W'(OUT_DEPTH - 2), "token taken without room for two results")
	`ESD_ASSERT_IMP(a_pair_held, symbols.valid && !symbols.last, stat.out_count >= OUT_CNT_W'(2), "first of a pair shown without its partner")
endmodule

### tb/tb_escape_sequence_decoder.sv
`timescale 1ns / 1ps

module tb_escape_sequence_decoder;
	import esd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 12;

	// receiver stall styles
	localparam logic [1:0] RX_ALWAYS   = 2'd0;
	localparam logic [1:0] RX_RANDOM   = 2'd1;
	localparam logic [1:0] RX_SPARSE   = 2'd2;
	localparam logic [1:0] RX_PERIODIC = 2'd3;

	// shapes of random character sequences
	typedef enum int {
		SEQ_PLAIN,
		SEQ_LETTER,
		SEQ_CARET,
		SEQ_HEX,
		SEQ_OCT,
		SEQ_OTHER,
		SEQ_END,
		SEQ_CUT_RUN
	} seq_kind_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	esd_in_if  char_if ();
	esd_out_if sym_if ();

	escape_sequence_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (char_if),
		.symbols (sym_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decoder shadow state
	logic [MODE_W-1:0] dec_mode;
	logic [VAL_W-1:0]  dec_acc;
	logic [1:0]        dec_digits;

	esd_result_t expected_syms[$];

	int cycle_count = 0;
	int fail_count = 0;
	int chars_sent = 0;
	int syms_checked = 0;
	int double_chars = 0;

	// sender pacing
	int max_gap = 0;
	int max_burst = 1;
	int burst_left = 0;

	// receiver pacing
	logic [1:0] rx_style = RX_ALWAYS;
	logic [7:0] rx_tick = '0;
	logic       hold_active = 1'b0;
	event       hold_kick;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'h20 : c;
	endfunction

	function automatic logic is_hex_digit(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
			(c >= "a" && c <= "f");
	endfunction

	function automatic logic is_oct_digit(input logic [7:0] c);
		return c >= "0" && c <= "7";
	endfunction

	function automatic logic [7:0] random_hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10)
			return 8'("0" + r);
		else if (r < 16)
			return 8'("a" + r - 10);
		return 8'("A" + r - 16);
	endfunction

	// Advance the shadow decoder by one character and queue its symbols.
	task automatic predict_char(input logic [7:0] c);
		logic [7:0]       u;
		logic [3:0]       hv;
		logic [VAL_W-1:0] syms[$];
		logic             handle_idle;
		esd_result_t      r;
		u = upcase(c);
		handle_idle = 1'b0;
		case (dec_mode)
			MODE_ESC: begin
				dec_mode = MODE_IDLE;
				if (c == CH_NUL)    syms.push_back(VAL_W'(CH_BSLASH));
				else if (u == "B")  syms.push_back(12'h008);
				else if (u == "F")  syms.push_back(12'h00C);
				else if (u == "N")  syms.push_back(12'h00A);
				else if (u == "R")  syms.push_back(12'h00D);
				else if (u == "S")  syms.push_back(12'h020);
				else if (u == "T")  syms.push_back(12'h009);
				else if (u == "E")  syms.push_back(VAL_W'(CH_ESCAPE));
				else if (c == CH_CARET) dec_mode = MODE_CARET;
				else if (u == "X") begin
					dec_mode = MODE_HEX;
					dec_acc = '0;
					dec_digits = '0;
				end else if (is_oct_digit(c)) begin
					dec_mode = MODE_OCT;
					dec_acc = VAL_W'(c[2:0]);
					dec_digits = 2'd1;
				end else begin
					syms.push_back(VAL_W'(c));
				end
			end
			MODE_CARET: begin
				dec_mode = MODE_IDLE;
				syms.push_back(VAL_W'(8'(u - CH_AT)));
			end
			MODE_HEX: begin
				if (is_hex_digit(c)) begin
					hv = (c <= "9") ? c[3:0] : 4'(u - "A" + 10);
					dec_acc = {dec_acc[VAL_W-5:0], hv};
					dec_digits = dec_digits + 2'd1;
					if (dec_digits == 2'd3) begin
						dec_mode = MODE_IDLE;
						syms.push_back(dec_acc);
					end
				end else begin
					dec_mode = MODE_IDLE;
					syms.push_back(dec_acc);
					handle_idle = 1'b1;
				end
			end
			MODE_OCT: begin
				if (is_oct_digit(c)) begin
					dec_acc = {dec_acc[VAL_W-4:0], c[2:0]};
					dec_digits = dec_digits + 2'd1;
					if (dec_digits == 2'd3) begin
						dec_mode = MODE_IDLE;
						syms.push_back(dec_acc);
					end
				end else begin
					dec_mode = MODE_IDLE;
					syms.push_back(dec_acc);
					handle_idle = 1'b1;
				end
			end
			default: begin
				dec_mode = MODE_IDLE;
				handle_idle = 1'b1;
			end
		endcase

		// character seen with no escape pending, also after a closed run
		if (handle_idle) begin
			if (c == CH_BSLASH)
				dec_mode = MODE_ESC;
			else if (c != CH_NUL)
				syms.push_back(VAL_W'(c));
		end

		if (syms.size() == 2)
			double_chars++;
		foreach (syms[i]) begin
			r.value = syms[i];
			r.last = (i == syms.size() - 1);
			expected_syms.push_back(r);
		end
	endtask

	// Offer one character, pacing in bursts, and wait for the request to go.
	task automatic send_char(input logic [7:0] c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, max_burst);
			gap = (max_gap == 0 || $urandom_range(0, 2) == 0) ? 0 :
				$urandom_range(1, max_gap);
			if (gap > 0) begin
				char_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		char_if.valid <= 1'b1;
		char_if.ch <= c;
		@(posedge clk);
		while (!char_if.ready)
			@(posedge clk);
		predict_char(c);
		chars_sent++;
		burst_left--;
	endtask

	// One random sequence; most are well formed sequences with random content.
	task automatic send_random_sequence(input int wellformed_pct, input logic runs_only);
		seq_kind_e  kind;
		int         n;
		logic [7:0] c;
		if ($urandom_range(0, 99) >= wellformed_pct) begin
			send_char(8'($urandom_range(0, 255)));
			return;
		end
		if (runs_only)
			kind = ($urandom_range(0, 2) == 0) ? SEQ_CUT_RUN :
				seq_kind_e'($urandom_range(SEQ_HEX, SEQ_OCT));
		else
			kind = seq_kind_e'($urandom_range(SEQ_PLAIN, SEQ_CUT_RUN));
		case (kind)
			SEQ_PLAIN: begin
				send_char(8'($urandom_range(1, 255)));
			end
			SEQ_LETTER: begin
				case ($urandom_range(0, 6))
					0: c = "b";
					1: c = "f";
					2: c = "n";
					3: c = "r";
					4: c = "s";
					5: c = "t";
					default: c = "e";
				endcase
				if ($urandom_range(0, 1) == 1)
					c = upcase(c);
				send_char(CH_BSLASH);
				send_char(c);
			end
			SEQ_CARET: begin
				send_char(CH_BSLASH);
				send_char(CH_CARET);
				send_char(8'($urandom_range(0, 255)));
			end
			SEQ_HEX: begin
				send_char(CH_BSLASH);
				send_char(($urandom_range(0, 1) == 1) ? "x" : "X");
				n = $urandom_range(0, 3);
				repeat (n) send_char(random_hex_char());
			end
			SEQ_OCT: begin
				send_char(CH_BSLASH);
				n = $urandom_range(1, 3);
				repeat (n) send_char(8'("0" + $urandom_range(0, 7)));
			end
			SEQ_OTHER: begin
				send_char(CH_BSLASH);
				send_char(8'($urandom_range(0, 255)));
			end
			SEQ_END: begin
				send_char(CH_NUL);
			end
			default: begin
				// escape or digit run cut short by end of string
				send_char(CH_BSLASH);
				n = $urandom_range(0, 2);
				repeat (n) send_char(8'("0" + $urandom_range(0, 7)));
				send_char(CH_NUL);
			end
		endcase
	endtask

	// Check each symbol taken and set the receiver's stall pattern.
	always @(posedge clk) begin
		esd_result_t want;
		if (arst_n && sym_if.valid && sym_if.ready) begin
			if (expected_syms.size() == 0) begin
				$error("unexpected symbol: value %0h last %0b", sym_if.value, sym_if.last);
				fail_count++;
			end else begin
				want = expected_syms.pop_front();
				if (sym_if.value !== want.value) begin
					$error("value mismatch: expected %0h, actual %0h",
						want.value, sym_if.value);
					fail_count++;
				end
				if (sym_if.last !== want.last) begin
					$error("last mismatch: expected %0b, actual %0b",
						want.last, sym_if.last);
					fail_count++;
				end
				syms_checked++;
			end
		end
		rx_tick <= rx_tick + 8'd1;
		if (!arst_n) begin
			sym_if.ready <= 1'b0;
		end else if (hold_active) begin
			sym_if.ready <= 1'b0;
		end else begin
			case (rx_style)
				RX_RANDOM:   sym_if.ready <= ($urandom_range(0, 3) != 0);
				RX_SPARSE:   sym_if.ready <= ($urandom_range(0, 3) == 0);
				RX_PERIODIC: sym_if.ready <= (rx_tick[2:0] < 3'd5);
				default:     sym_if.ready <= 1'b1;
			endcase
		end
	end

	// long receiver hold-off, counted here
	always begin
		@(hold_kick);
		hold_active <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_active <= 1'b0;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

	task automatic test_directed();
		logic [7:0] chars [0:26];
		chars = '{
			8'hFF, CH_NUL,                          // byte extreme, NUL while idle
			CH_BSLASH, CH_CARET, CH_NUL,            // caret then end of string
			CH_BSLASH, "x", "F", "f", "F",          // three hex digits, max value
			CH_BSLASH, "x", "g",                    // empty hex run, then plain char
			CH_BSLASH, "7", "7", "7",               // three octal digits, max value
			CH_BSLASH, "1", CH_BSLASH, "n",         // octal run ended by a new escape
			CH_BSLASH, "X", "1", CH_NUL,            // hex run then end of string
			CH_BSLASH, CH_NUL                       // backslash then end of string
		};
		max_gap = 0;
		max_burst = 1;
		rx_style <= RX_ALWAYS;
		foreach (chars[i])
			send_char(chars[i]);
	endtask

	task automatic test_random_mix();
		int stop_at;
		stop_at = chars_sent + 900;
		while (chars_sent < stop_at) begin
			if ($urandom_range(0, 59) == 0) begin
				max_gap = $urandom_range(0, 6);
				max_burst = $urandom_range(1, 16);
				rx_style <= 2'($urandom_range(0, 3));
			end
			send_random_sequence(85, 1'b0);
		end
	endtask

	task automatic test_unpaced();
		int stop_at;
		stop_at = chars_sent + 250;
		max_gap = 0;
		max_burst = 32;
		rx_style <= RX_ALWAYS;
		while (chars_sent < stop_at)
			send_random_sequence(90, 1'b0);
	endtask

	task automatic test_receiver_holdoff();
		int stop_at;
		stop_at = chars_sent + 200;
		max_gap = 0;
		max_burst = 64;
		rx_style <= RX_RANDOM;
		-> hold_kick;
		while (chars_sent < stop_at)
			send_random_sequence(90, 1'b0);
	endtask

	task automatic test_digit_runs();
		int stop_at;
		stop_at = chars_sent + 450;
		max_gap = 3;
		max_burst = 8;
		rx_style <= RX_PERIODIC;
		while (chars_sent < stop_at) begin
			send_random_sequence(80, 1'b1);
			// new stall pattern only when more characters follow
			if ($urandom_range(0, 79) == 0 && chars_sent < stop_at)
				rx_style <= 2'($urandom_range(0, 3));
		end
	endtask

	initial begin
		char_if.valid = 1'b0;
		char_if.ch = '0;
		dec_mode = MODE_IDLE;
		dec_acc = '0;
		dec_digits = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix();
		test_unpaced();
		test_receiver_holdoff();
		test_digit_runs();

		// drain
		char_if.valid <= 1'b0;
		rx_style <= RX_ALWAYS;
		while (expected_syms.size() != 0 || hold_active)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_syms.size() != 0) begin
			$error("%0d symbols never arrived", expected_syms.size());
			fail_count++;
		end

		$display("Sent %0d characters (escapes, caret codes, hex and octal runs, noise)",
			chars_sent);
		$display("Checked %0d symbols, %0d characters gave two; gaps, stalls, long hold-off",
			syms_checked, double_chars);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### escape_sequence_decoder.f
+incdir+hdl
hdl/esd_pkg.sv
hdl/esd_in_if.sv
hdl/esd_out_if.sv
hdl/esd_front.sv
hdl/esd_queue.sv
hdl/esd_back.sv
hdl/escape_sequence_decoder.sv
tb/tb_escape_sequence_decoder.sv
